>>> design/cbl_pkg.sv
package cbl_pkg;

    // Table geometry
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int MAX_DIGITS      = 9;
    localparam int MIN_DIGITS      = 6;
    localparam int DIGIT_W         = 4;
    localparam int DIGITS_W        = MAX_DIGITS * DIGIT_W;
    localparam int LEN_W           = 4;
    localparam int VAL_W           = 16;

    // Request kinds (tuser)
    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_CLEAR  = 2'd1;
    localparam logic [1:0] REQ_APPEND = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEF_CVK = 2'd0;
    localparam logic [1:0] CFG_DEF_PVK = 2'd1;
    localparam logic [1:0] CFG_DEF_CVV = 2'd2;
    localparam logic [1:0] CFG_DEF_PVV = 2'd3;

    // Values carried by one table entry and one result
    typedef struct packed {
        logic [VAL_W-1:0] pvv_alg;
        logic [VAL_W-1:0] cvv_alg;
        logic [VAL_W-1:0] pvk_handle;
        logic [VAL_W-1:0] cvk_handle;
    } t_values;

    // One table entry as stored in memory
    typedef struct packed {
        t_values             vals;
        logic [LEN_W-1:0]    prefix_len;
        logic [DIGITS_W-1:0] prefix;
    } t_entry;

    // One result item
    typedef struct packed {
        t_values vals;
        logic    matched;
        logic    status;
    } t_result;

    // Engine status seen by the top level
    typedef struct packed {
        logic idle;
        logic full;
    } t_eng_stat;

endpackage

>>> design/cbl_ram.sv
module cbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/cbl_engine.sv
module cbl_engine #(
    parameter int TABLE_DEPTH = cbl_pkg::TABLE_DEPTH_DEF,
    parameter int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request side
    input  logic                         i_req_valid,
    input  logic [1:0]                   i_req_type,
    input  logic [cbl_pkg::DIGITS_W-1:0] i_card,
    input  cbl_pkg::t_entry              i_new_entry,
    // defaults for a lookup without a hit
    input  cbl_pkg::t_values             i_defaults,
    // result side
    output logic                         o_res_valid,
    input  logic                         i_res_take,
    output cbl_pkg::t_result             o_res,
    output cbl_pkg::t_eng_stat           o_stat
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_LAST = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    logic [1:0]                   r_state;
    logic [CW-1:0]                r_count;
    logic [AW-1:0]                r_idx;
    logic                         r_rd_vld;
    logic [cbl_pkg::DIGITS_W-1:0] r_card;
    logic [cbl_pkg::LEN_W-1:0]    r_best_len;
    cbl_pkg::t_values             r_best;
    logic                         r_is_lookup;
    logic                         r_status;

    logic                         accept;
    logic                         full;
    logic                         wr_en;
    cbl_pkg::t_entry              rd_entry;
    logic [cbl_pkg::DIGITS_W-1:0] mask;
    logic                         len_ok;
    logic                         hit;
    logic                         matched;

    // Keeps the top n digits of a nine-digit word, n from six to nine
    function automatic logic [cbl_pkg::DIGITS_W-1:0] digit_mask(
        input logic [cbl_pkg::LEN_W-1:0] len
    );
        logic [cbl_pkg::DIGITS_W-1:0] m;
        case (len)
            4'd9:    m = 36'hFFFFFFFFF;
            4'd8:    m = 36'hFFFFFFFF0;
            4'd7:    m = 36'hFFFFFFF00;
            4'd6:    m = 36'hFFFFFF000;
            default: m = '0;
        endcase
        return m;
    endfunction

    assign accept = i_req_valid && (r_state == ST_IDLE);
    assign full   = (r_count >= DEPTH_C);
    assign wr_en  = accept && (i_req_type == cbl_pkg::REQ_APPEND) && !full;

    // Entry table: appends write at the fill count, scans read one entry a cycle
    cbl_ram #(
        .WIDTH ($bits(cbl_pkg::t_entry)),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_new_entry),
        .i_raddr (r_idx),
        .o_rdata (rd_entry)
    );

    // Compare the entry read last cycle; a strictly longer length wins,
    // so the lowest index is kept among equal lengths
    assign mask   = digit_mask(rd_entry.prefix_len);
    assign len_ok = (rd_entry.prefix_len >= cbl_pkg::LEN_W'(cbl_pkg::MIN_DIGITS)) &&
                    (rd_entry.prefix_len <= cbl_pkg::LEN_W'(cbl_pkg::MAX_DIGITS));
    assign hit    = r_rd_vld && len_ok &&
                    (((rd_entry.prefix ^ r_card) & mask) == '0) &&
                    (rd_entry.prefix_len > r_best_len);

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == ST_SCAN);
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        case (i_req_type)
                            cbl_pkg::REQ_LOOKUP: begin
                                r_state <= (r_count != '0) ? ST_SCAN : ST_DONE;
                            end
                            cbl_pkg::REQ_CLEAR: begin
                                r_state <= ST_DONE;
                                r_count <= '0;
                            end
                            cbl_pkg::REQ_APPEND: begin
                                r_state <= ST_DONE;
                                if (!full) begin
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            default: begin
                                r_state <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (CW'(r_idx) + 1'b1 == r_count) begin
                        r_state <= ST_LAST;
                    end
                end
                ST_LAST: begin
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (i_res_take) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Request payload and best-hit tracking
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_card      <= i_card;
            r_idx       <= '0;
            r_best_len  <= '0;
            r_is_lookup <= (i_req_type == cbl_pkg::REQ_LOOKUP);
            r_status    <= (i_req_type == cbl_pkg::REQ_APPEND) && full;
        end else begin
            if (r_state == ST_SCAN) begin
                r_idx <= r_idx + 1'b1;
            end
            if (hit) begin
                r_best_len <= rd_entry.prefix_len;
                r_best     <= rd_entry.vals;
            end
        end
    end

    // Result
    assign matched           = r_is_lookup && (r_best_len != '0);
    assign o_res_valid       = (r_state == ST_DONE);
    assign o_res.status      = r_status;
    assign o_res.matched     = matched;
    assign o_res.vals        = matched     ? r_best :
                               r_is_lookup ? i_defaults : '0;
    assign o_stat.idle       = (r_state == ST_IDLE);
    assign o_stat.full       = full;

endmodule

>>> design/card_bin_longest_prefix_lookup_top.sv
// Channel | Dir | Signals              | Contents (lowest bit up)
// s_axis  | in  | tvalid tready tdata  | card_digits, new_prefix, new_prefix_len,
//         |     | tuser                | new_cvk/pvk_handle, new_cvv/pvv_alg; tuser req_type
// m_axis  | out | tvalid tready tdata  | status, matched, cvk/pvk_handle_out, cvv/pvv_alg_out
// cfg     | in  | we idx data          | default cvk, pvk, cvv, pvv
//
// A clear, an append or a lookup on an empty table goes from the idle state to
// the done state and from there into the result register. A lookup over N stored
// entries passes through the scan and last-compare states before the done state:
// the scan reads one entry per cycle from the memory. One item is in work at a
// time; a result held back by the output register stalls the input until it
// moves. Reset is synchronous and empties the table.
module card_bin_longest_prefix_lookup_top #(
    parameter int TABLE_DEPTH = cbl_pkg::TABLE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // card_digits[35:0], new_prefix[71:36], new_prefix_len[75:72],
    // new_cvk_handle[91:76], new_pvk_handle[107:92], new_cvv_alg[123:108],
    // new_pvv_alg[139:124], zero fill [143:140]
    input  logic [143:0] s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]   s_axis_tuser,
    // output stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[0], matched[1], cvk_handle_out[17:2], pvk_handle_out[33:18],
    // cvv_alg_out[49:34], pvv_alg_out[65:50], zero fill [71:66]
    output logic [71:0]  m_axis_tdata,
    // configuration writes
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data
);

    cbl_pkg::t_values    r_defaults;
    logic                r_out_valid;
    cbl_pkg::t_result    r_out;

    cbl_pkg::t_entry     new_entry;
    cbl_pkg::t_result    eng_res;
    cbl_pkg::t_eng_stat  eng_stat;
    logic                eng_valid;
    logic                out_load;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_defaults <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cbl_pkg::CFG_DEF_CVK: r_defaults.cvk_handle <= i_cfg_data;
                cbl_pkg::CFG_DEF_PVK: r_defaults.pvk_handle <= i_cfg_data;
                cbl_pkg::CFG_DEF_CVV: r_defaults.cvv_alg    <= i_cfg_data;
                cbl_pkg::CFG_DEF_PVV: r_defaults.pvv_alg    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Unpack the append payload
    assign new_entry.prefix          = s_axis_tdata[71:36];
    assign new_entry.prefix_len      = s_axis_tdata[75:72];
    assign new_entry.vals.cvk_handle = s_axis_tdata[91:76];
    assign new_entry.vals.pvk_handle = s_axis_tdata[107:92];
    assign new_entry.vals.cvv_alg    = s_axis_tdata[123:108];
    assign new_entry.vals.pvv_alg    = s_axis_tdata[139:124];

    cbl_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_type  (s_axis_tuser),
        .i_card      (s_axis_tdata[35:0]),
        .i_new_entry (new_entry),
        .i_defaults  (r_defaults),
        .o_res_valid (eng_valid),
        .i_res_take  (out_load),
        .o_res       (eng_res),
        .o_stat      (eng_stat)
    );

    assign s_axis_tready = eng_stat.idle;

    // Output register, loaded when empty or being drained
    assign out_load = eng_valid && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= eng_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out.vals.pvv_alg, r_out.vals.cvv_alg,
                            r_out.vals.pvk_handle, r_out.vals.cvk_handle,
                            r_out.matched, r_out.status};

`ifndef SYNTH
    // An accepted item occupies the engine until its result is handed over
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken again before result handed over");

    // A dropped append never reports a match
    a_status_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status) |-> !r_out.matched)
        else $error("dropped append reported a match");

    // An append on a full table is always reported as dropped
    a_full_append_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && eng_stat.full &&
         (s_axis_tuser == cbl_pkg::REQ_APPEND)) |=> eng_res.status)
        else $error("append on full table not flagged");
`endif

endmodule
